// File: hw/rtl/fixed_partition_allocator_defines.svh
// Assertion macros used by the allocator top level.
`ifndef FIXED_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
`define FPA_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("allocator assertion failed");
`else
`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FPA_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/fpa_pkg.sv
// Types, constants and codes of the fixed-partition allocator.
package fpa_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
    localparam int ACT_BITS  = 5;
    localparam int CMP_BITS  = (CNT_BITS > ACT_BITS) ? CNT_BITS : ACT_BITS;
    localparam int EXT_BITS  = 20;
    localparam int SUM_BITS  = ((SIZE_BITS > EXT_BITS) ? SIZE_BITS : EXT_BITS) + 1;
    localparam logic [EXT_BITS-1:0] EXT_MAX = '1;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_ALLOC = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd1;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_BITS-1:0]  best_idx;
        logic [SIZE_BITS-1:0] best_size;
        logic [EXT_BITS-1:0]  free_sum;
    } fpa_token_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic mark;
        logic active;
    } fpa_cell_ctl_t;

endpackage

// File: hw/rtl/fixed_partition_allocator.sv
// Top level of the fixed-partition allocator: control, registers and the slot chain.
//
//  channel  | ports                                   | carries
//  ---------+-----------------------------------------+-------------------------------
//  input    | s_valid s_ready s_req_type ...          | load, clear or allocate beat
//  result   | m_valid m_ready m_status ...            | one result beat per item
//  config   | psel penable pwrite paddr pwdata ...    | fit_policy, active_blocks
//
// An allocate sends a start beat that walks the slot chain one cell per cycle; the
// result and output registers follow. Load, clear and unknown items skip the scan.
// Reset is synchronous and clears every slot size and used bit at once.
// A new item is taken while the previous result still waits in the output register;
// its own result then holds until that register is free.
`include "fixed_partition_allocator_defines.svh"

module fixed_partition_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [3:0]  s_slot_index,
    input  logic [15:0] s_size_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_chosen_slot,
    output logic [15:0] m_internal_frag,
    output logic [19:0] m_external_frag,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           policy_reg;
    logic [ACT_BITS-1:0]  active_reg;
    logic                 start_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [1:0]           res_status_reg, res_status_next;
    logic [3:0]           res_slot_reg, res_slot_next;
    logic [15:0]          res_int_reg, res_int_next;
    logic [19:0]          res_ext_reg, res_ext_next;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [3:0]           m_slot_reg;
    logic [15:0]          m_int_reg;
    logic [19:0]          m_ext_reg;
    logic                 in_fire, cfg_wr, scan_end, out_load;
    logic [CMP_BITS-1:0]  act_sat;
    logic [SIZE_BITS-1:0] in_size;
    fpa_token_t           tok [0:NUM_SLOTS];
    fpa_token_t           tok_last;
    logic [NUM_SLOTS-1:0] tok_vec;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_ACTIVE) ? 32'(active_reg) : 32'(policy_reg);
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign in_size  = SIZE_BITS'(s_size_value);
    assign tok_last = tok[NUM_SLOTS];
    assign scan_end = tok_last.valid;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign act_sat  = (CMP_BITS'(active_reg) > CMP_BITS'(NUM_SLOTS))
                    ? CMP_BITS'(NUM_SLOTS) : CMP_BITS'(active_reg);

    always_comb begin
        tok[0]           = '0;
        tok[0].valid     = start_reg;
    end

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        fpa_cell_ctl_t ctl;
        always_comb begin
            ctl.load   = in_fire && (s_req_type == REQ_LOAD) && (32'(s_slot_index) == k);
            ctl.clear  = in_fire && (s_req_type == REQ_CLEAR);
            ctl.mark   = scan_end && tok_last.found && (32'(tok_last.best_idx) == k);
            ctl.active = (32'(act_sat) > k);
        end
        fpa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .load_size (in_size),
            .req_size  (req_reg),
            .policy    (policy_reg),
            .cell_idx  (IDX_BITS'(k)),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1])
        );
        assign tok_vec[k] = tok[k+1].valid;
    end

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_int_next    = res_int_reg;
        res_ext_next    = res_ext_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    res_status_next = ST_DONE;
                    res_slot_next   = '0;
                    res_int_next    = '0;
                    res_ext_next    = '0;
                    state_next      = (s_req_type == REQ_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DONE;
                    if (tok_last.found) begin
                        res_status_next = ST_ALLOC;
                        res_slot_next   = 4'(tok_last.best_idx);
                        res_int_next    = 16'(tok_last.best_size - req_reg);
                    end else begin
                        res_status_next = ST_NOFIT;
                        res_ext_next    = tok_last.free_sum;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            policy_reg  <= 2'd0;
            active_reg  <= ACT_BITS'(16);
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_fire && (s_req_type == REQ_ALLOC);
            if (cfg_wr && (paddr[2] == REG_POLICY)) begin
                policy_reg <= pwdata[1:0];
            end
            if (cfg_wr && (paddr[2] == REG_ACTIVE)) begin
                active_reg <= pwdata[ACT_BITS-1:0];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (in_fire) begin
            req_reg <= in_size;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_int_reg    <= res_int_next;
        res_ext_reg    <= res_ext_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_int_reg    <= res_int_reg;
            m_ext_reg    <= res_ext_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_chosen_slot   = m_slot_reg;
    assign m_internal_frag = m_int_reg;
    assign m_external_frag = m_ext_reg;

    `FPA_ASSERT_ALWAYS(a_one_scan_beat, aclk, aresetn, $onehot0({tok_vec, start_reg}))
    `FPA_ASSERT_IMP(a_idle_no_beat, aclk, aresetn, state_reg == S_IDLE, tok_vec == '0)
    `FPA_ASSERT_IMP(a_end_in_scan, aclk, aresetn, scan_end, state_reg == S_SCAN)
    `FPA_ASSERT_IMP(a_alloc_no_ext, aclk, aresetn, res_status_reg == ST_ALLOC, res_ext_reg == '0)

endmodule

// File: hw/rtl/fpa_cell.sv
// One partition slot: holds its size and used bit and updates the passing scan beat.
module fpa_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fpa_pkg::fpa_cell_ctl_t       ctl,
    input  logic [fpa_pkg::SIZE_BITS-1:0] load_size,
    input  logic [fpa_pkg::SIZE_BITS-1:0] req_size,
    input  logic [1:0]                   policy,
    input  logic [fpa_pkg::IDX_BITS-1:0]  cell_idx,
    input  fpa_pkg::fpa_token_t          tok_in,
    output fpa_pkg::fpa_token_t          tok_out
);
    import fpa_pkg::*;

    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 used_reg, used_next;
    fpa_token_t           tok_reg, tok_next;
    logic                 fits, better;
    logic [SUM_BITS-1:0]  sum_wide;

    always_comb begin
        size_next = size_reg;
        used_next = used_reg;
        priority if (ctl.clear) begin
            used_next = 1'b0;
        end else if (ctl.load) begin
            size_next = load_size;
            used_next = 1'b0;
        end else if (ctl.mark) begin
            used_next = 1'b1;
        end
    end

    always_comb begin
        fits     = ctl.active && !used_reg && (size_reg >= req_size);
        better   = policy[1] ? (size_reg > tok_in.best_size)
                             : (size_reg < tok_in.best_size);
        sum_wide = SUM_BITS'(tok_in.free_sum) + SUM_BITS'(size_reg);
        tok_next = tok_in;
        if (fits && (!tok_in.found || (policy != POL_FIRST && better))) begin
            tok_next.found     = 1'b1;
            tok_next.best_idx  = cell_idx;
            tok_next.best_size = size_reg;
        end
        if (ctl.active && !used_reg) begin
            if (sum_wide > SUM_BITS'(EXT_MAX)) begin
                tok_next.free_sum = EXT_MAX;
            end else begin
                tok_next.free_sum = sum_wide[EXT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            size_reg      <= size_next;
            used_reg      <= used_next;
            tok_reg.valid <= tok_in.valid;
        end
        tok_reg.found     <= tok_next.found;
        tok_reg.best_idx  <= tok_next.best_idx;
        tok_reg.best_size <= tok_next.best_size;
        tok_reg.free_sum  <= tok_next.free_sum;
    end

    assign tok_out = tok_reg;

endmodule
